[sv/kil_pkg.sv]
// Shared types and constants for the keyword/identifier lexer.
// No dependencies; used by kil_lex, kil_tok_fifo and the top level.
package kil_pkg;

  typedef enum logic [4:0] {
    TOK_HASH   = 5'd0,
    TOK_BEGIN  = 5'd1,
    TOK_IF     = 5'd2,
    TOK_THEN   = 5'd3,
    TOK_WHILE  = 5'd4,
    TOK_DO     = 5'd5,
    TOK_END    = 5'd6,
    TOK_ID     = 5'd7,
    TOK_NUM    = 5'd8,
    TOK_ADD    = 5'd9,
    TOK_SUB    = 5'd10,
    TOK_MUL    = 5'd11,
    TOK_DIV    = 5'd12,
    TOK_ASSIGN = 5'd13,
    TOK_LT     = 5'd14,
    TOK_NE     = 5'd15,
    TOK_LE     = 5'd16,
    TOK_GT     = 5'd17,
    TOK_GE     = 5'd18,
    TOK_EQ     = 5'd19,
    TOK_SEMI   = 5'd20,
    TOK_LPAREN = 5'd21,
    TOK_RPAREN = 5'd22,
    TOK_ERROR  = 5'd23
  } tok_type_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_COLON = 3'd3,
    MODE_LT    = 3'd4,
    MODE_GT    = 3'd5
  } lex_mode_e;

  typedef struct packed {
    tok_type_e  ttype;
    logic [6:0] len;
  } tok_t;

  // Tokens produced by one character: count is 0, 1 or 2, tok0 goes out first.
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } lex_out_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } tok_entry_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PrefixChars = 5;

  // Keyword spellings with the first character in the low byte.
  localparam logic [39:0] KwBegin = 40'h6E69676562;
  localparam logic [39:0] KwIf    = 40'h0000006669;
  localparam logic [39:0] KwThen  = 40'h006E656874;
  localparam logic [39:0] KwWhile = 40'h656C696877;
  localparam logic [39:0] KwDo    = 40'h0000006F64;
  localparam logic [39:0] KwEnd   = 40'h0000646E65;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChHash   = 8'h23;

endpackage

[sv/kil_lex.sv]
// Lexer state registers and the per-character transition logic.
// Depends on kil_pkg.
module kil_lex #(
  parameter int unsigned LEN_CAP = 127
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        ch,
  output kil_pkg::lex_out_t lex_out
);

  kil_pkg::lex_mode_e mode, mode_next;
  logic [6:0]  word_length, word_length_next;
  logic [39:0] word_prefix, word_prefix_next;

  logic is_space, is_digit, is_alpha;
  logic hold, consumed, fresh_emit;
  kil_pkg::tok_t pend_tok, fresh_tok;
  logic          pend_emit;
  kil_pkg::tok_type_e word_type;

  assign is_space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_digit = (ch >= 8'd48) && (ch <= 8'd57);
  assign is_alpha = (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);

  // Prefix bytes past the word length are always zero, so a full compare works.
  always_comb begin
    word_type = kil_pkg::TOK_ID;
    if (word_length == 7'd5 && word_prefix == kil_pkg::KwBegin) begin
      word_type = kil_pkg::TOK_BEGIN;
    end else if (word_length == 7'd2 && word_prefix == kil_pkg::KwIf) begin
      word_type = kil_pkg::TOK_IF;
    end else if (word_length == 7'd4 && word_prefix == kil_pkg::KwThen) begin
      word_type = kil_pkg::TOK_THEN;
    end else if (word_length == 7'd5 && word_prefix == kil_pkg::KwWhile) begin
      word_type = kil_pkg::TOK_WHILE;
    end else if (word_length == 7'd2 && word_prefix == kil_pkg::KwDo) begin
      word_type = kil_pkg::TOK_DO;
    end else if (word_length == 7'd3 && word_prefix == kil_pkg::KwEnd) begin
      word_type = kil_pkg::TOK_END;
    end
  end

  // Token that ends with this character, or that this character closes.
  always_comb begin
    hold      = 1'b0;
    consumed  = 1'b0;
    pend_emit = 1'b0;
    pend_tok  = '{ttype: kil_pkg::TOK_ERROR, len: 7'd1};
    unique case (mode)
      kil_pkg::MODE_WORD: begin
        if (is_alpha || is_digit) begin
          hold = 1'b1;
        end else begin
          pend_emit = 1'b1;
          pend_tok  = '{ttype: word_type, len: word_length};
        end
      end
      kil_pkg::MODE_NUM: begin
        if (is_digit) begin
          hold = 1'b1;
        end else begin
          pend_emit = 1'b1;
          pend_tok  = '{ttype: kil_pkg::TOK_NUM, len: word_length};
        end
      end
      kil_pkg::MODE_COLON: begin
        pend_emit = 1'b1;
        if (ch == kil_pkg::ChEq) begin
          consumed = 1'b1;
          pend_tok = '{ttype: kil_pkg::TOK_ASSIGN, len: 7'd2};
        end
      end
      kil_pkg::MODE_LT: begin
        pend_emit = 1'b1;
        if (ch == kil_pkg::ChEq) begin
          consumed = 1'b1;
          pend_tok = '{ttype: kil_pkg::TOK_LE, len: 7'd2};
        end else if (ch == kil_pkg::ChGt) begin
          consumed = 1'b1;
          pend_tok = '{ttype: kil_pkg::TOK_NE, len: 7'd2};
        end else begin
          pend_tok = '{ttype: kil_pkg::TOK_LT, len: 7'd1};
        end
      end
      kil_pkg::MODE_GT: begin
        pend_emit = 1'b1;
        if (ch == kil_pkg::ChEq) begin
          consumed = 1'b1;
          pend_tok = '{ttype: kil_pkg::TOK_GE, len: 7'd2};
        end else begin
          pend_tok = '{ttype: kil_pkg::TOK_GT, len: 7'd1};
        end
      end
      default: begin
      end
    endcase
  end

  // Next state and the token this character makes on its own.
  always_comb begin
    mode_next        = kil_pkg::MODE_IDLE;
    word_length_next = '0;
    word_prefix_next = '0;
    fresh_emit       = 1'b0;
    fresh_tok        = '{ttype: kil_pkg::TOK_ERROR, len: 7'd1};
    if (hold) begin
      mode_next        = mode;
      word_prefix_next = word_prefix;
      if (word_length < 7'(kil_pkg::PrefixChars)) begin
        word_prefix_next = word_prefix | (40'(ch) << {word_length[2:0], 3'b000});
      end
      word_length_next = (word_length < 7'(LEN_CAP)) ? word_length + 7'd1 : word_length;
    end else if (!consumed && !is_space) begin
      if (is_alpha) begin
        mode_next        = kil_pkg::MODE_WORD;
        word_length_next = 7'd1;
        word_prefix_next = 40'(ch);
      end else if (is_digit) begin
        mode_next        = kil_pkg::MODE_NUM;
        word_length_next = 7'd1;
      end else begin
        case (ch)
          kil_pkg::ChColon: mode_next = kil_pkg::MODE_COLON;
          kil_pkg::ChLt:    mode_next = kil_pkg::MODE_LT;
          kil_pkg::ChGt:    mode_next = kil_pkg::MODE_GT;
          default: begin
            fresh_emit = 1'b1;
            case (ch)
              kil_pkg::ChPlus:   fresh_tok.ttype = kil_pkg::TOK_ADD;
              kil_pkg::ChMinus:  fresh_tok.ttype = kil_pkg::TOK_SUB;
              kil_pkg::ChStar:   fresh_tok.ttype = kil_pkg::TOK_MUL;
              kil_pkg::ChSlash:  fresh_tok.ttype = kil_pkg::TOK_DIV;
              kil_pkg::ChEq:     fresh_tok.ttype = kil_pkg::TOK_EQ;
              kil_pkg::ChSemi:   fresh_tok.ttype = kil_pkg::TOK_SEMI;
              kil_pkg::ChLparen: fresh_tok.ttype = kil_pkg::TOK_LPAREN;
              kil_pkg::ChRparen: fresh_tok.ttype = kil_pkg::TOK_RPAREN;
              kil_pkg::ChHash:   fresh_tok.ttype = kil_pkg::TOK_HASH;
              default:           fresh_tok.ttype = kil_pkg::TOK_ERROR;
            endcase
          end
        endcase
      end
    end
  end

  always_comb begin
    lex_out.count = {1'b0, pend_emit} + {1'b0, fresh_emit};
    lex_out.tok0  = pend_emit ? pend_tok : fresh_tok;
    lex_out.tok1  = fresh_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= kil_pkg::MODE_IDLE;
      word_length <= '0;
      word_prefix <= '0;
    end else if (advance) begin
      mode        <= mode_next;
      word_length <= word_length_next;
      word_prefix <= word_prefix_next;
    end
  end

endmodule

[sv/kil_tok_fifo.sv]
// Small token queue that takes up to two tokens a cycle and gives one.
// Depends on kil_pkg.
module kil_tok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kil_pkg::lex_out_t   lex_out,
  input  logic                pop,
  output logic                out_valid,
  output kil_pkg::tok_entry_t out_entry,
  output logic [2:0]          count
);

  kil_pkg::tok_entry_t entries [kil_pkg::FifoDepth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [1:0] push_n;
  logic       do_pop;

  assign push_n    = push ? lex_out.count : 2'd0;
  assign out_valid = (count != 3'd0);
  assign do_pop    = pop && out_valid;
  assign out_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= '{tok: lex_out.tok0, last: (lex_out.count == 2'd1)};
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + 2'd1] <= '{tok: lex_out.tok1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      count  <= count + {1'b0, push_n} - {2'b00, do_pop};
    end
  end

endmodule

[sv/keyword_identifier_lexer_core.sv]
// Top level of the streaming keyword/identifier lexer: input register,
// lexer step and token queue. Depends on kil_pkg, kil_lex and kil_tok_fifo.
//
//   Channel  Dir  Signals                      Beat
//   s_axis   in   tvalid tready tdata[7:0]     one character
//   m_axis   out  tvalid tready tdata tlast    one token
//
// One character is taken per cycle while the token queue has room; a token
// is offered once its closing character has passed the input register and
// been written into the queue. A character that closes two tokens fills
// two output beats, so input can stall even at one token taken per cycle.
// Reset clears the lexer state and the four-entry token queue.
// The lexer stalls whenever the queue has fewer than two free entries.
module keyword_identifier_lexer_core #(
  parameter int unsigned MAX_WORD_LEN = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] token_type, [11:5] token_length
  output logic        m_axis_tlast    // last
);

  localparam int unsigned LenCap = (MAX_WORD_LEN > 127) ? 127 : MAX_WORD_LEN;

  logic       in_valid;
  logic [7:0] in_char;
  logic       advance;
  logic [2:0] fifo_count;

  kil_pkg::lex_out_t   lex_out;
  kil_pkg::tok_entry_t out_entry;

  // Two free entries are needed since one character can close two tokens.
  assign advance       = in_valid && (fifo_count <= 3'(kil_pkg::FifoDepth - 2));
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
    end
  end

  kil_lex #(
    .LEN_CAP(LenCap)
  ) u_lex (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ch      (in_char),
    .lex_out (lex_out)
  );

  kil_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .lex_out   (lex_out),
    .pop       (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_entry (out_entry),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {4'b0000, out_entry.tok.len, out_entry.tok.ttype};
  assign m_axis_tlast = out_entry.last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= 3'(kil_pkg::FifoDepth))
    else $error("token queue overflow");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second token of a character missing");

  a_room_on_advance: assert property (@(posedge clk) disable iff (rst)
    advance |-> (fifo_count <= 3'(kil_pkg::FifoDepth - 2)))
    else $error("lexer advanced without room for two tokens");

endmodule

[sim/tb_keyword_identifier_lexer_core.sv]
// Self-checking testbench for keyword_identifier_lexer_core: drives character beats,
// predicts the token stream in step with accepted beats and checks each token beat.
// Depends on kil_pkg and the lexer RTL.
`timescale 1ns / 1ps

module tb_keyword_identifier_lexer_core;

  localparam int LenCap = 127;

  typedef struct {
    kil_pkg::tok_type_e kind;
    logic [6:0]         len;
    logic               last;
  } token_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  keyword_identifier_lexer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predicted lexer state.
  kil_pkg::lex_mode_e lx_mode;
  logic [6:0]         lx_len;
  logic [39:0]        lx_prefix;

  token_t expected_tokens[$];
  int     mismatches;
  int     chars_sent;
  int     gap_pct;
  int     stall_pct;

  string kw_list[6] = '{"begin", "end", "if", "then", "while", "do"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num_char(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic token_t mk_tok(input kil_pkg::tok_type_e kind, input logic [6:0] len);
    token_t t;
    t.kind = kind;
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  // The stored prefix is zero above the word, so a whole-vector compare
  // together with the exact length identifies a keyword.
  function automatic kil_pkg::tok_type_e word_kind(input logic [6:0] n,
                                                   input logic [39:0] p);
    if (n == 7'd5 && p == kil_pkg::KwBegin) return kil_pkg::TOK_BEGIN;
    if (n == 7'd2 && p == kil_pkg::KwIf) return kil_pkg::TOK_IF;
    if (n == 7'd4 && p == kil_pkg::KwThen) return kil_pkg::TOK_THEN;
    if (n == 7'd5 && p == kil_pkg::KwWhile) return kil_pkg::TOK_WHILE;
    if (n == 7'd2 && p == kil_pkg::KwDo) return kil_pkg::TOK_DO;
    if (n == 7'd3 && p == kil_pkg::KwEnd) return kil_pkg::TOK_END;
    return kil_pkg::TOK_ID;
  endfunction

  function automatic void grow_word(input logic [7:0] c);
    if (lx_len < 7'd5) lx_prefix[8 * int'(lx_len) +: 8] = c;
    if (int'(lx_len) < LenCap) lx_len = lx_len + 7'd1;
  endfunction

  // Lexes a character from the idle mode; returns 1 when it makes a token at once.
  function automatic bit fresh_token(input logic [7:0] c, output token_t t);
    kil_pkg::tok_type_e k;
    k = kil_pkg::TOK_ERROR;
    if (is_blank(c)) return 1'b0;
    if (is_letter(c)) begin
      lx_mode   = kil_pkg::MODE_WORD;
      lx_len    = 7'd1;
      lx_prefix = {32'd0, c};
      return 1'b0;
    end
    if (is_num_char(c)) begin
      lx_mode   = kil_pkg::MODE_NUM;
      lx_len    = 7'd1;
      lx_prefix = 40'd0;
      return 1'b0;
    end
    case (c)
      kil_pkg::ChColon: begin
        lx_mode = kil_pkg::MODE_COLON;
        return 1'b0;
      end
      kil_pkg::ChLt: begin
        lx_mode = kil_pkg::MODE_LT;
        return 1'b0;
      end
      kil_pkg::ChGt: begin
        lx_mode = kil_pkg::MODE_GT;
        return 1'b0;
      end
      kil_pkg::ChPlus:   k = kil_pkg::TOK_ADD;
      kil_pkg::ChMinus:  k = kil_pkg::TOK_SUB;
      kil_pkg::ChStar:   k = kil_pkg::TOK_MUL;
      kil_pkg::ChSlash:  k = kil_pkg::TOK_DIV;
      kil_pkg::ChEq:     k = kil_pkg::TOK_EQ;
      kil_pkg::ChSemi:   k = kil_pkg::TOK_SEMI;
      kil_pkg::ChLparen: k = kil_pkg::TOK_LPAREN;
      kil_pkg::ChRparen: k = kil_pkg::TOK_RPAREN;
      kil_pkg::ChHash:   k = kil_pkg::TOK_HASH;
      default:           k = kil_pkg::TOK_ERROR;
    endcase
    t = mk_tok(k, 7'd1);
    return 1'b1;
  endfunction

  // Advances the predicted lexer by one accepted character and queues its tokens.
  function automatic void lex_char(input logic [7:0] c);
    token_t step_toks[$];
    token_t t;
    bit     taken;
    taken = 1'b0;
    case (lx_mode)
      kil_pkg::MODE_WORD: begin
        if (is_letter(c) || is_num_char(c)) begin
          grow_word(c);
          return;
        end
        step_toks.push_back(mk_tok(word_kind(lx_len, lx_prefix), lx_len));
      end
      kil_pkg::MODE_NUM: begin
        if (is_num_char(c)) begin
          grow_word(c);
          return;
        end
        step_toks.push_back(mk_tok(kil_pkg::TOK_NUM, lx_len));
      end
      kil_pkg::MODE_COLON: begin
        if (c == kil_pkg::ChEq) begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_ASSIGN, 7'd2));
          taken = 1'b1;
        end else begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_ERROR, 7'd1));
        end
      end
      kil_pkg::MODE_LT: begin
        if (c == kil_pkg::ChEq) begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_LE, 7'd2));
          taken = 1'b1;
        end else if (c == kil_pkg::ChGt) begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_NE, 7'd2));
          taken = 1'b1;
        end else begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_LT, 7'd1));
        end
      end
      kil_pkg::MODE_GT: begin
        if (c == kil_pkg::ChEq) begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_GE, 7'd2));
          taken = 1'b1;
        end else begin
          step_toks.push_back(mk_tok(kil_pkg::TOK_GT, 7'd1));
        end
      end
      default: ;
    endcase
    lx_mode   = kil_pkg::MODE_IDLE;
    lx_len    = 7'd0;
    lx_prefix = 40'd0;
    if (!taken && fresh_token(c, t)) step_toks.push_back(t);
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'd65 + 8'(r);
    if (r < 52) return 8'd97 + 8'(r - 26);
    return 8'd48 + 8'(r - 52);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    if (r < 26) return 8'd65 + 8'(r);
    return 8'd97 + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    if (r == 5) return 8'd32;
    return 8'd9 + 8'(r);
  endfunction

  // Sends one character beat; valid stays high afterwards so that beats can
  // follow back to back.
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    lex_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // One token with random content (sometimes a lone colon, which lexes as an error), then maybe a separator.
  task automatic send_token_run();
    string kw;
    string ops;
    int    n;
    ops = "+-*/=;()#<>";
    kw  = kw_list[$urandom_range(0, 5)];
    case ($urandom_range(0, 9))
      0, 1: send_text(kw);
      2: begin
        // Near misses: truncated, extended or capitalized keywords.
        case ($urandom_range(0, 2))
          0: for (int i = 0; i < kw.len() - 1; i++) send_char(kw[i]);
          1: begin
            send_text(kw);
            send_char(rand_alnum());
          end
          default: begin
            send_char(kw[0] - 8'd32);
            for (int i = 1; i < kw.len(); i++) send_char(kw[i]);
          end
        endcase
      end
      3, 4: begin
        n = $urandom_range(0, 7);
        send_char(rand_letter());
        repeat (n) send_char(rand_alnum());
      end
      5: begin
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'd48 + 8'($urandom_range(0, 9)));
      end
      6: begin
        case ($urandom_range(0, 3))
          0: send_text(":=");
          1: send_text("<=");
          2: send_text("<>");
          default: send_text(">=");
        endcase
      end
      7, 8: begin
        n = $urandom_range(0, 10);
        send_char(ops[n]);
      end
      default: send_char(kil_pkg::ChColon);
    endcase
    case ($urandom_range(0, 3))
      0, 1: ;
      2: send_char(8'd32);
      default: send_char(rand_blank());
    endcase
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    while (expected_tokens.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic test_directed();
    gap_pct   = 25;
    stall_pct = 25;
    send_text("if:=9<>x<=1>=;(#:+-*/)=<a>");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_text("\t");
  endtask

  // Word and number lengths at and beyond the saturation point.
  task automatic test_long_tokens();
    gap_pct   = 15;
    stall_pct = 30;
    send_text("begin");
    repeat (125) send_char(rand_alnum());
    send_char(kil_pkg::ChSemi);
    send_char(rand_letter());
    repeat (126) send_char(rand_alnum());
    send_char(8'd32);
    repeat (128) send_char(8'd48 + 8'($urandom_range(0, 9)));
    send_char(kil_pkg::ChLt);
    send_text("while5\n");
  endtask

  task automatic test_token_stream();
    int next_change;
    int stop_at;
    stop_at     = chars_sent + 510;
    next_change = chars_sent;
    while (chars_sent < stop_at) begin
      if (chars_sent >= next_change) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 20;
          default: gap_pct = 45;
        endcase
        stall_pct   = 10 * $urandom_range(0, 5);
        next_change = chars_sent + 50;
      end
      // Within a ten-character window the sender holds off until every predicted token has arrived.
      if (chars_sent >= stop_at - 300 && chars_sent < stop_at - 290) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait_drain();
      end
      send_token_run();
    end
  endtask

  task automatic test_noise();
    int stop_at;
    logic [7:0] lead;
    gap_pct   = 30;
    stall_pct = 30;
    stop_at   = chars_sent + 200;
    while (chars_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_char(8'($urandom_range(0, 255)));
        6, 7: begin
          case ($urandom_range(0, 2))
            0: lead = kil_pkg::ChColon;
            1: lead = kil_pkg::ChLt;
            default: lead = kil_pkg::ChGt;
          endcase
          send_char(lead);
          send_char(8'($urandom_range(0, 255)));
        end
        default: send_token_run();
      endcase
    end
  endtask

  task automatic test_full_rate();
    int stop_at;
    gap_pct   = 0;
    stall_pct = 0;
    stop_at   = chars_sent + 200;
    while (chars_sent < stop_at) send_token_run();
    send_char(8'd32);
  endtask

  // Sink side: random stall bursts.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t     want;
    logic [4:0] got_kind;
    logic [6:0] got_len;
    got_kind = m_axis_tdata[4:0];
    got_len  = m_axis_tdata[11:5];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        flag($sformatf("unexpected token beat type %0d len %0d last %0b",
                       got_kind, got_len, m_axis_tlast));
      end else begin
        want = expected_tokens.pop_front();
        if (got_kind !== want.kind || got_len !== want.len || m_axis_tlast !== want.last)
          flag($sformatf("expected type %0d len %0d last %0b, got type %0d len %0d last %0b",
                         want.kind, want.len, want.last, got_kind, got_len, m_axis_tlast));
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    lx_mode       = kil_pkg::MODE_IDLE;
    lx_len        = 7'd0;
    lx_prefix     = 40'd0;
    mismatches    = 0;
    chars_sent    = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_long_tokens();
    test_token_stream();
    test_noise();
    test_full_rate();

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait_drain();
    repeat (16) @(posedge clk);
    if (expected_tokens.size() != 0)
      flag($sformatf("%0d expected tokens never arrived", expected_tokens.size()));

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[keyword_identifier_lexer_core.f]
sv/kil_pkg.sv
sv/kil_lex.sv
sv/kil_tok_fifo.sv
sv/keyword_identifier_lexer_core.sv
sim/tb_keyword_identifier_lexer_core.sv
